/* sv/erl_pkg.sv */
// shared types and codes for the event ring log
package erl_pkg;

  localparam int HostW = 32;
  localparam int SeqW  = 64;
  localparam int EvKindW = 8;
  localparam int CountW  = 6;

  typedef logic [1:0] op_t;
  localparam op_t OP_APPEND_NEW  = 2'd0;
  localparam op_t OP_APPEND_KEEP = 2'd1;
  localparam op_t OP_TAIL_READ   = 2'd2;

  typedef logic [1:0] res_kind_t;
  localparam res_kind_t KIND_ACK   = 2'd0;
  localparam res_kind_t KIND_ENTRY = 2'd1;
  localparam res_kind_t KIND_EMPTY = 2'd2;

  typedef struct packed {
    logic [HostW-1:0]   host;
    logic [SeqW-1:0]    sequence_no;
    logic [HostW-1:0]   trigger_host;
    logic [SeqW-1:0]    cause_sequence;
    logic [EvKindW-1:0] ev_kind;
  } record_t;

endpackage

/* sv/erl_store.sv */
// record store of the ring: one write port, one registered read port
module erl_store #(
  parameter int SLOTS = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(SLOTS)-1:0] wr_addr,
  input  erl_pkg::record_t         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(SLOTS)-1:0] rd_addr,
  output erl_pkg::record_t         rd_data
);
  import erl_pkg::*;

  record_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/event_ring_log_with_tail_read.sv */
// top level of the event ring log with tail read
//
// Input channel (in_valid/in_stall) takes one request per beat: an append
// that stamps a new sequence number, an append that keeps given_sequence,
// or a tail read. Operation code 3 is taken and ignored.
// Output channel (out_valid/out_stall) gives result beats from one output
// register; last marks the final beat of a request.
// The block holds one request at a time: in_stall is high from the cycle
// after acceptance until the request's final result is in the output
// register, so a result may still wait there while the next request goes in.
// Append: the ack is written to the output register from the append state
// once the output is free. Tail read: the record store has one read port
// with a registered read, and one shared 64-bit compare checks each entry,
// so each entry visited passes a read state and a compare state, and a walk
// that ends on the count or at the oldest entry ends in a flush state; a
// read of an empty ring goes straight to the flush state.
// The final entry is held back one step, so last can be set on it.
// Reset (rst, synchronous) empties the ring, sets the next sequence to 1
// and drops any pending result; no clearing pass is needed.
// A stall on the output freezes the sequencer at its next emit.
module event_ring_log_with_tail_read #(
  parameter int SLOTS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    operation,
  input  logic [erl_pkg::HostW-1:0]     host,
  input  logic [erl_pkg::SeqW-1:0]      given_sequence,
  input  logic [erl_pkg::HostW-1:0]     trigger_host,
  input  logic [erl_pkg::SeqW-1:0]      cause_sequence,
  input  logic [erl_pkg::EvKindW-1:0]   event_kind,
  input  logic [erl_pkg::SeqW-1:0]      earliest,
  input  logic [erl_pkg::CountW-1:0]    max_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    kind,
  output logic [erl_pkg::SeqW-1:0]      sequence_res,
  output logic [erl_pkg::HostW-1:0]     entry_host,
  output logic [erl_pkg::HostW-1:0]     entry_cause_host,
  output logic [erl_pkg::SeqW-1:0]      entry_cause_sequence,
  output logic [erl_pkg::EvKindW-1:0]   entry_kind,
  output logic                          dropped_oldest,
  output logic                          last
);
  import erl_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam logic [IW-1:0] LastSlot = IW'(SLOTS - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_APPEND = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_CMP    = 3'd3;
  localparam logic [2:0] S_FLUSH  = 3'd4;

  logic [2:0]        state;
  logic [IW-1:0]     head_index;
  logic [IW-1:0]     tail_index;
  logic [SeqW-1:0]   next_sequence;
  logic [IW-1:0]     curr;
  logic [CountW-1:0] count;
  logic [CountW-1:0] limit;
  logic              held_valid;
  record_t           held;
  op_t               req_op;
  record_t           req_rec;
  logic [SeqW-1:0]   req_earliest;

  record_t           rd_data;
  logic              rd_en;
  logic              wr_en;
  logic [IW-1:0]     head_step;
  logic [IW-1:0]     tail_step;
  logic [IW-1:0]     curr_back;
  logic              ring_full;
  record_t           wr_rec;
  logic              seq_pass;
  logic [CountW:0]   count_inc;
  logic              walk_stop;
  logic              out_free;

  logic              emit;
  res_kind_t         emit_kind;
  record_t           emit_rec;
  logic              emit_drop;
  logic              emit_last;

  assign head_step = (head_index == LastSlot) ? '0 : head_index + 1'b1;
  assign tail_step = (tail_index == LastSlot) ? '0 : tail_index + 1'b1;
  assign curr_back = (curr == '0) ? LastSlot : curr - 1'b1;
  assign ring_full = (head_step == tail_index);

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);

  // shared compare of the stored sequence against the lower bound
  assign seq_pass  = (rd_data.sequence_no >= req_earliest);
  assign count_inc = {1'b0, count} + 1'b1;
  assign walk_stop = (count_inc >= {1'b0, limit}) || (curr_back == tail_index);

  assign rd_en = (state == S_READ);
  assign wr_en = (state == S_APPEND) && out_free;

  always_comb begin
    wr_rec = req_rec;
    if (req_op == OP_APPEND_NEW) begin
      wr_rec.sequence_no = next_sequence;
    end
  end

  erl_store #(.SLOTS(SLOTS)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (head_step),
    .wr_data (wr_rec),
    .rd_en   (rd_en),
    .rd_addr (curr),
    .rd_data (rd_data)
  );

  always_comb begin
    emit      = 1'b0;
    emit_kind = KIND_EMPTY;
    emit_rec  = '0;
    emit_drop = 1'b0;
    emit_last = 1'b1;
    unique case (state)
      S_APPEND: begin
        emit                 = out_free;
        emit_kind            = KIND_ACK;
        emit_rec.sequence_no = wr_rec.sequence_no;
        emit_drop            = ring_full;
      end
      S_CMP: begin
        if (seq_pass) begin
          emit      = out_free && held_valid;
          emit_kind = KIND_ENTRY;
          emit_rec  = held;
          emit_last = 1'b0;
        end else begin
          emit = out_free;
          if (held_valid) begin
            emit_kind = KIND_ENTRY;
            emit_rec  = held;
          end
        end
      end
      S_FLUSH: begin
        emit = out_free;
        if (held_valid) begin
          emit_kind = KIND_ENTRY;
          emit_rec  = held;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      head_index    <= '0;
      tail_index    <= '0;
      next_sequence <= SeqW'(1);
      held_valid    <= 1'b0;
      count         <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            curr       <= head_index;
            count      <= '0;
            held_valid <= 1'b0;
            if (operation == OP_APPEND_NEW || operation == OP_APPEND_KEEP) begin
              state <= S_APPEND;
            end else if (operation == OP_TAIL_READ) begin
              state <= (head_index == tail_index) ? S_FLUSH : S_READ;
            end
          end
        end
        S_APPEND: begin
          if (out_free) begin
            if (ring_full) begin
              tail_index <= tail_step;
            end
            head_index <= head_step;
            if (req_op == OP_APPEND_NEW) begin
              next_sequence <= next_sequence + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (out_free) begin
            if (seq_pass) begin
              held_valid <= 1'b1;
              count      <= count_inc[CountW-1:0];
              curr       <= curr_back;
              state      <= walk_stop ? S_FLUSH : S_READ;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // request and held entry payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      req_op                 <= operation;
      req_rec.host           <= host;
      req_rec.sequence_no    <= given_sequence;
      req_rec.trigger_host   <= trigger_host;
      req_rec.cause_sequence <= cause_sequence;
      req_rec.ev_kind        <= event_kind;
      req_earliest           <= earliest;
      limit                  <= (max_count == '0) ? CountW'(1) : max_count;
    end
    if (state == S_CMP && out_free && seq_pass) begin
      held <= rd_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind                 <= emit_kind;
      sequence_res         <= emit_rec.sequence_no;
      entry_host           <= emit_rec.host;
      entry_cause_host     <= emit_rec.trigger_host;
      entry_cause_sequence <= emit_rec.cause_sequence;
      entry_kind           <= emit_rec.ev_kind;
      dropped_oldest       <= emit_drop;
      last                 <= emit_last;
    end
  end

endmodule

/* sv/erl_checker.sv */
// port checks on the event ring log, bound to the top level
module erl_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic [1:0]                  operation,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [1:0]                  kind,
  input logic [erl_pkg::SeqW-1:0]    sequence_res,
  input logic [erl_pkg::HostW-1:0]   entry_host,
  input logic                        dropped_oldest,
  input logic                        last
);
  import erl_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(sequence_res)
      && $stable(last))
    else $error("stalled result beat changed");

  a_ack_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_ACK |-> last && entry_host == '0)
    else $error("append ack not a single final beat");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_EMPTY |-> last && sequence_res == '0 && !dropped_oldest)
    else $error("empty result not clean");

  a_entry_nodrop: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_ENTRY |-> !dropped_oldest)
    else $error("tail entry flagged as drop");

  // one request at a time: a working beat taken means the next cycle is busy
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (operation == OP_APPEND_NEW || operation == OP_APPEND_KEEP
      || operation == OP_TAIL_READ) |=> in_stall)
    else $error("request taken while another in flight");

endmodule

bind event_ring_log_with_tail_read erl_checker u_erl_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .operation      (operation),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .kind           (kind),
  .sequence_res   (sequence_res),
  .entry_host     (entry_host),
  .dropped_oldest (dropped_oldest),
  .last           (last)
);

/* tb/sv/event_ring_log_with_tail_read_tb.sv */
// testbench for the event ring log: ring predictor, directed walks and random appends and reads
module event_ring_log_with_tail_read_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import erl_pkg::*;

  localparam int RingSlots = 64;
  localparam int CycleLimit = 1_000_000;
  localparam int DrainCycles = 200;
  localparam op_t OP_RESERVED = 2'd3;

  typedef struct {
    op_t                op;
    logic [HostW-1:0]   host;
    logic [SeqW-1:0]    given;
    logic [HostW-1:0]   trigger_host;
    logic [SeqW-1:0]    cause_seq;
    logic [EvKindW-1:0] ev_kind;
    logic [SeqW-1:0]    earliest;
    logic [CountW-1:0]  max_count;
  } request_t;

  typedef struct {
    res_kind_t          k;
    logic [SeqW-1:0]    seq;
    logic [HostW-1:0]   host;
    logic [HostW-1:0]   trigger_host;
    logic [SeqW-1:0]    cause_seq;
    logic [EvKindW-1:0] ev_kind;
    logic               drop;
    logic               fin;
  } beat_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           operation = '0;
  logic [HostW-1:0]     host = '0;
  logic [SeqW-1:0]      given_sequence = '0;
  logic [HostW-1:0]     trigger_host = '0;
  logic [SeqW-1:0]      cause_sequence = '0;
  logic [EvKindW-1:0]   event_kind = '0;
  logic [SeqW-1:0]      earliest = '0;
  logic [CountW-1:0]    max_count = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           kind;
  logic [SeqW-1:0]      sequence_res;
  logic [HostW-1:0]     entry_host;
  logic [HostW-1:0]     entry_cause_host;
  logic [SeqW-1:0]      entry_cause_sequence;
  logic [EvKindW-1:0]   entry_kind;
  logic                 dropped_oldest;
  logic                 last;

  // ring copy kept in step with accepted requests
  logic [HostW-1:0]     ring_host [RingSlots];
  logic [SeqW-1:0]      ring_seq [RingSlots];
  logic [HostW-1:0]     ring_cause_host [RingSlots];
  logic [SeqW-1:0]      ring_cause_seq [RingSlots];
  logic [EvKindW-1:0]   ring_kind [RingSlots];
  int                   head_ix = 0;
  int                   tail_ix = 0;
  logic [SeqW-1:0]      seq_counter = 64'd1;

  beat_t                pending_results[$];
  int                   errors = 0;
  int                   cycles = 0;
  int                   idle_pct = 0;
  int                   stall_pct = 0;

  event_ring_log_with_tail_read #(
    .SLOTS(RingSlots)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .operation(operation),
    .host(host),
    .given_sequence(given_sequence),
    .trigger_host(trigger_host),
    .cause_sequence(cause_sequence),
    .event_kind(event_kind),
    .earliest(earliest),
    .max_count(max_count),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind(kind),
    .sequence_res(sequence_res),
    .entry_host(entry_host),
    .entry_cause_host(entry_cause_host),
    .entry_cause_sequence(entry_cause_sequence),
    .entry_kind(entry_kind),
    .dropped_oldest(dropped_oldest),
    .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("event_ring_log_with_tail_read: mismatch");
      $finish;
    end
  end

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  function automatic beat_t make_beat(input res_kind_t k, input logic [SeqW-1:0] seq,
                                      input logic [HostW-1:0] h, input logic [HostW-1:0] ch,
                                      input logic [SeqW-1:0] cs, input logic [EvKindW-1:0] ek,
                                      input logic drop, input logic fin);
    beat_t b;
    b.k = k;
    b.seq = seq;
    b.host = h;
    b.trigger_host = ch;
    b.cause_seq = cs;
    b.ev_kind = ek;
    b.drop = drop;
    b.fin = fin;
    return b;
  endfunction

  function automatic request_t make_request(input op_t op, input logic [HostW-1:0] h,
                                            input logic [SeqW-1:0] g,
                                            input logic [HostW-1:0] ch,
                                            input logic [SeqW-1:0] cs,
                                            input logic [EvKindW-1:0] ek,
                                            input logic [SeqW-1:0] e,
                                            input logic [CountW-1:0] m);
    request_t r;
    r.op = op;
    r.host = h;
    r.given = g;
    r.trigger_host = ch;
    r.cause_seq = cs;
    r.ev_kind = ek;
    r.earliest = e;
    r.max_count = m;
    return r;
  endfunction

  // appends stamp and store a record, tail reads walk back from the newest entry
  task automatic log_request(input request_t r);
    logic [SeqW-1:0] stamp;
    logic            dropped;
    int              slot;
    int              cur;
    int              lim;
    int              n;
    case (r.op)
      OP_APPEND_NEW, OP_APPEND_KEEP: begin
        if (r.op == OP_APPEND_NEW) begin
          stamp = seq_counter;
          seq_counter = seq_counter + 64'd1;
        end else begin
          stamp = r.given;
        end
        dropped = 1'b0;
        slot = (head_ix + 1) % RingSlots;
        if (slot == tail_ix) begin
          tail_ix = (tail_ix + 1) % RingSlots;
          dropped = 1'b1;
        end
        ring_host[slot] = r.host;
        ring_seq[slot] = stamp;
        ring_cause_host[slot] = r.trigger_host;
        ring_cause_seq[slot] = r.cause_seq;
        ring_kind[slot] = r.ev_kind;
        head_ix = slot;
        pending_results.push_back(make_beat(KIND_ACK, stamp, '0, '0, '0, '0, dropped, 1'b1));
      end
      OP_TAIL_READ: begin
        lim = (r.max_count == 0) ? 1 : int'(r.max_count);
        n = 0;
        if (head_ix != tail_ix) begin
          cur = head_ix;
          while (ring_seq[cur] >= r.earliest) begin
            pending_results.push_back(make_beat(KIND_ENTRY, ring_seq[cur], ring_host[cur],
                                                ring_cause_host[cur], ring_cause_seq[cur],
                                                ring_kind[cur], 1'b0, 1'b0));
            n++;
            if (n >= lim) break;
            cur = (cur + RingSlots - 1) % RingSlots;
            if (cur == tail_ix) break;
          end
        end
        if (n == 0)
          pending_results.push_back(make_beat(KIND_EMPTY, '0, '0, '0, '0, '0, 1'b0, 1'b1));
        else
          pending_results[pending_results.size() - 1].fin = 1'b1;
      end
      default: ;
    endcase
  endtask

  function automatic void check_field(input string what, input logic [SeqW-1:0] want,
                                      input logic [SeqW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, what, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: beat with nothing expected, kind %0d sequence %h", $time, kind,
                 sequence_res);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 64'(want.k), 64'(kind));
        check_field("sequence_res", want.seq, sequence_res);
        check_field("entry_host", 64'(want.host), 64'(entry_host));
        check_field("entry_cause_host", 64'(want.trigger_host), 64'(entry_cause_host));
        check_field("entry_cause_sequence", want.cause_seq, entry_cause_sequence);
        check_field("entry_kind", 64'(want.ev_kind), 64'(entry_kind));
        check_field("dropped_oldest", 64'(want.drop), 64'(dropped_oldest));
        check_field("last", 64'(want.fin), 64'(last));
      end
    end
  end

  task automatic send_request(input request_t r);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    operation <= r.op;
    host <= r.host;
    given_sequence <= r.given;
    trigger_host <= r.trigger_host;
    cause_sequence <= r.cause_seq;
    event_kind <= r.ev_kind;
    earliest <= r.earliest;
    max_count <= r.max_count;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    log_request(r);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic request_t random_request();
    request_t r;
    int       pick;
    int       live;
    r.host = $urandom;
    r.given = {$urandom, $urandom};
    r.trigger_host = $urandom;
    r.cause_seq = {$urandom, $urandom};
    r.ev_kind = EvKindW'($urandom);
    r.earliest = {$urandom, $urandom};
    r.max_count = CountW'($urandom);
    pick = $urandom_range(99);
    if (pick < 60) r.op = OP_APPEND_NEW;
    else if (pick < 75) r.op = OP_APPEND_KEEP;
    else if (pick < 97) r.op = OP_TAIL_READ;
    else r.op = OP_RESERVED;
    // kept sequences mostly near the running count so walks get past them
    if (r.op == OP_APPEND_KEEP && $urandom_range(3) != 0)
      r.given = seq_counter + 64'($urandom_range(8)) - 64'd4;
    if (r.op == OP_TAIL_READ) begin
      live = (head_ix - tail_ix + RingSlots) % RingSlots;
      pick = $urandom_range(99);
      if (pick < 40 && live > 0)
        r.earliest = ring_seq[(tail_ix + 1 + int'($urandom_range(live - 1))) % RingSlots];
      else if (pick < 60) r.earliest = '0;
      else if (pick < 80) r.earliest = seq_counter - 64'($urandom_range(70));
      else if (pick < 90) r.earliest = '1;
      if ($urandom_range(3) == 0) r.max_count = '1;
    end
    return r;
  endfunction

  task automatic run_random(input int items);
    request_t r;
    int       sent;
    sent = 0;
    while (sent < items) begin
      r = random_request();
      send_request(r);
      if (r.op != OP_RESERVED) sent++;
    end
  endtask

  task automatic test_empty_ring();
    send_request(make_request(OP_TAIL_READ, '0, '0, '0, '0, '0, '0, '0));
    send_request(make_request(OP_RESERVED, '1, '1, '1, '1, '1, '1, '1));
    send_request(make_request(OP_TAIL_READ, '1, '1, '1, '1, '1, '1, '1));
  endtask

  task automatic test_append_extremes();
    send_request(make_request(OP_APPEND_NEW, '1, '1, '1, '1, '1, '1, '1));
    send_request(make_request(OP_APPEND_NEW, '0, '0, '0, '0, '0, '0, '0));
    send_request(make_request(OP_APPEND_KEEP, $urandom, '1, $urandom, {$urandom, $urandom},
                              EvKindW'($urandom), '0, '0));
    send_request(make_request(OP_APPEND_KEEP, $urandom, '0, $urandom, {$urandom, $urandom},
                              EvKindW'($urandom), '0, '0));
    send_request(make_request(OP_APPEND_NEW, $urandom, '0, $urandom, {$urandom, $urandom},
                              EvKindW'($urandom), '0, '0));
  endtask

  // ring now holds 1, 2, all ones, 0, 3 from oldest to newest
  task automatic test_tail_walk();
    send_request(make_request(OP_TAIL_READ, '0, '0, '0, '0, '0, '0, '0));
    send_request(make_request(OP_TAIL_READ, '0, '0, '0, '0, '0, '0, '1));
    send_request(make_request(OP_TAIL_READ, '0, '0, '0, '0, '0, 64'd1, '1));
    send_request(make_request(OP_TAIL_READ, '0, '0, '0, '0, '0, '1, '1));
    send_request(make_request(OP_TAIL_READ, '0, '0, '0, '0, '0, 64'd2, 6'd2));
    send_request(make_request(OP_RESERVED, '0, '0, '0, '0, '0, '0, '0));
    wait_for_results();
    send_request(make_request(OP_TAIL_READ, '0, '0, '0, '0, '0, '0, 6'd3));
  endtask

  task automatic test_overflow();
    request_t r;
    repeat (66) begin
      r = random_request();
      r.op = OP_APPEND_NEW;
      send_request(r);
    end
    send_request(make_request(OP_TAIL_READ, '0, '0, '0, '0, '0, '0, '1));
    send_request(make_request(OP_TAIL_READ, '0, '0, '0, '0, '0, '0, 6'd62));
  endtask

  task automatic test_random_no_idle();
    idle_pct = 0;
    stall_pct = 0;
    run_random(24);
  endtask

  task automatic test_random_sender_idle();
    idle_pct = 77;
    stall_pct = 0;
    run_random(24);
  endtask

  task automatic test_random_receiver_stall();
    idle_pct = 0;
    stall_pct = 77;
    run_random(24);
  endtask

  task automatic test_random_both();
    idle_pct = 33;
    stall_pct = 33;
    run_random(24);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_empty_ring();
    test_append_extremes();
    test_tail_walk();
    test_overflow();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both();
    wait_for_results();
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0)
      $display("event_ring_log_with_tail_read: match");
    else
      $display("event_ring_log_with_tail_read: mismatch");
    $finish;
  end

endmodule
